// ----- rtl/tofh_pkg.sv -----
// ----------------------------------------------------------------------------
// tofh_pkg
// Shared types, constants and helpers of the time-of-flight histogrammer.
// ----------------------------------------------------------------------------
`default_nettype none

package tofh_pkg;

    // Histogram geometry.
    localparam int HIST_BINS = 4096;
    localparam int BIN_AW    = $clog2(HIST_BINS);

    // Field widths.
    localparam int TIME_W  = 20;
    localparam int CNT_W   = 32;
    localparam int FRAME_W = 16;
    localparam int CMD_W   = 2;
    localparam int ADDR_W  = 12;
    localparam int WORD_W  = 32;

    // Saturation limits.
    localparam logic [CNT_W-1:0]   CNT_MAX   = {CNT_W{1'b1}};
    localparam logic [FRAME_W-1:0] STARTS_MAX = {FRAME_W{1'b1}};

    typedef logic [BIN_AW-1:0] t_bin_addr;
    typedef logic [CNT_W-1:0]  t_count;

    // Command codes carried with each input transfer.
    typedef enum logic [CMD_W-1:0] {
        CMD_EVENT      = 2'd0,
        CMD_READ       = 2'd1,
        CMD_READ_CLEAR = 2'd2
    } t_cmd;

    // Kind of result transfer.
    typedef enum logic {
        KIND_FRAME = 1'b0,
        KIND_BIN   = 1'b1
    } t_kind;

    // Decoded event handed to the framing logic.
    typedef struct packed {
        logic valid;
        logic is_start;
        logic in_range;
    } t_evt;

    // Summary of the frame that is currently open.
    typedef struct packed {
        logic               close;
        logic [FRAME_W-1:0] number;
        t_count             hits;
        t_count             dropped;
    } t_frame_sum;

    // Saturating increment of a counter.
    function automatic t_count sat_inc(input t_count v);
        t_count r;
        r = (v == CNT_MAX) ? v : v + 1'b1;
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/tofh_hist_ram.sv -----
// ----------------------------------------------------------------------------
// tofh_hist_ram
// Histogram store: one write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module tofh_hist_ram (
    input  wire logic               i_clk,
    input  wire logic               i_we,
    input  wire tofh_pkg::t_bin_addr i_waddr,
    input  wire tofh_pkg::t_count    i_wdata,
    input  wire tofh_pkg::t_bin_addr i_raddr,
    output      tofh_pkg::t_count    o_rdata
);

    tofh_pkg::t_count r_mem [tofh_pkg::HIST_BINS];
    tofh_pkg::t_count r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, read-before-write on a shared address.
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- rtl/tofh_frame_ctrl.sv -----
// ----------------------------------------------------------------------------
// tofh_frame_ctrl
// Frame bookkeeping: start counting, hit and out-of-range totals, frame index.
// ----------------------------------------------------------------------------
`default_nettype none

module tofh_frame_ctrl (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire tofh_pkg::t_evt                   i_evt,
    input  wire logic [tofh_pkg::FRAME_W-1:0]     i_frame_size,
    output      tofh_pkg::t_frame_sum             o_sum
);

    logic                         r_open,      n_open;
    logic [tofh_pkg::FRAME_W-1:0] r_starts,    n_starts;
    tofh_pkg::t_count             r_hits,      n_hits;
    tofh_pkg::t_count             r_dropped,   n_dropped;
    logic [tofh_pkg::FRAME_W-1:0] r_frame_cnt, n_frame_cnt;
    logic                         w_hit;
    logic                         w_close;

    assign w_hit   = i_evt.valid && !i_evt.is_start;
    // A frame size of zero behaves as one, since an open frame holds one start.
    assign w_close = i_evt.valid && r_open && i_evt.is_start && (r_starts >= i_frame_size);

    // Next frame state for the event in the update stage.
    always_comb begin
        n_open      = r_open;
        n_starts    = r_starts;
        n_hits      = r_hits;
        n_dropped   = r_dropped;
        n_frame_cnt = r_frame_cnt;
        if (i_evt.valid) begin
            if (!r_open) begin
                // The first event opens frame zero and is its opening item.
                n_open    = 1'b1;
                n_starts  = tofh_pkg::FRAME_W'(1);
                n_hits    = tofh_pkg::t_count'(w_hit);
                n_dropped = tofh_pkg::t_count'(w_hit && !i_evt.in_range);
            end else if (i_evt.is_start) begin
                if (w_close) begin
                    n_frame_cnt = r_frame_cnt + 1'b1;
                    n_starts    = tofh_pkg::FRAME_W'(1);
                    n_hits      = '0;
                    n_dropped   = '0;
                end else if (r_starts != tofh_pkg::STARTS_MAX) begin
                    n_starts = r_starts + 1'b1;
                end
            end else begin
                n_hits = tofh_pkg::sat_inc(r_hits);
                if (!i_evt.in_range) begin
                    n_dropped = tofh_pkg::sat_inc(r_dropped);
                end
            end
        end
    end

    // Frame state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open      <= 1'b0;
            r_starts    <= '0;
            r_hits      <= '0;
            r_dropped   <= '0;
            r_frame_cnt <= '0;
        end else begin
            r_open      <= n_open;
            r_starts    <= n_starts;
            r_hits      <= n_hits;
            r_dropped   <= n_dropped;
            r_frame_cnt <= n_frame_cnt;
        end
    end

    // Summary of the frame that closes with this start.
    always_comb begin
        o_sum.close   = w_close;
        o_sum.number  = r_frame_cnt;
        o_sum.hits    = r_hits;
        o_sum.dropped = r_dropped;
    end

endmodule

`default_nettype wire

// ----- rtl/tof_histogram_frame_counter.sv -----
// ----------------------------------------------------------------------------
// tof_histogram_frame_counter
// Time-of-flight histogrammer with frame counter and bin readout.
// ----------------------------------------------------------------------------
// Usage:
// An input transfer happens at a rising edge with start high and busy low. It
// carries a command (event word, read bin, read and clear bin), a raw TDC
// word and a bin address. Each transfer enters a two-step pipeline: the
// histogram memory read is issued at the accepting edge, and the next cycle
// modifies the bin and writes it back. A write forwarding register covers a
// following item that touches the same bin, so one item is taken every cycle
// while busy is low. A result (a closed frame summary or bin read data) shows
// on the o_ ports for one cycle with o_result_valid; it is built in the update
// stage of its input transfer and held in the output registers.
// The receiver cannot stall; results are never held back.
// After reset, busy stays high while a clearing pass zeroes the histogram
// memory one bin per cycle. Frame state, the frame index and the frame size
// (reset to one) are cleared at once. The frame size is written through the
// configuration channel, which is always ready.
// ----------------------------------------------------------------------------
`default_nettype none

module tof_histogram_frame_counter (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // Command channel.
    input  wire logic                              start,
    output      logic                              busy,
    input  wire logic [tofh_pkg::CMD_W-1:0]        i_command,
    input  wire logic [tofh_pkg::WORD_W-1:0]       i_event_word,
    input  wire logic [tofh_pkg::ADDR_W-1:0]       i_bin_address,
    // Configuration channel.
    input  wire logic                              i_cfg_valid,
    output      logic                              o_cfg_ready,
    input  wire logic [tofh_pkg::FRAME_W-1:0]      i_cfg_data,
    // Result channel.
    output      logic                              o_result_valid,
    output      logic                              o_result_kind,
    output      logic [tofh_pkg::FRAME_W-1:0]      o_frame_number,
    output      logic [tofh_pkg::CNT_W-1:0]        o_count,
    output      logic [tofh_pkg::CNT_W-1:0]        o_out_of_range_hits
);

    logic                         w_accept;
    logic [tofh_pkg::TIME_W-1:0]  w_time;
    logic [31:0]                  w_time_m1;
    logic [31:0]                  w_bin_ext;
    logic                         w_is_start;
    logic                         w_in_range;
    logic                         w_addr_ok;
    tofh_pkg::t_bin_addr          w_ev_addr;
    tofh_pkg::t_bin_addr          w_rd_addr;
    tofh_pkg::t_bin_addr          w_raddr;

    logic                         r_s1_valid;
    tofh_pkg::t_cmd               r_s1_cmd;
    logic                         r_s1_start;
    logic                         r_s1_in_range;
    logic                         r_s1_addr_ok;
    tofh_pkg::t_bin_addr          r_s1_addr;

    logic                         r_clr_active;
    tofh_pkg::t_bin_addr          r_clr_addr;

    logic                         r_fwd_valid;
    tofh_pkg::t_bin_addr          r_fwd_addr;
    tofh_pkg::t_count             r_fwd_data;

    logic [tofh_pkg::FRAME_W-1:0] r_frame_size;

    tofh_pkg::t_count             w_ram_rdata;
    tofh_pkg::t_count             w_old;
    logic                         w_upd_we;
    tofh_pkg::t_count             w_upd_data;
    logic                         w_ram_we;
    tofh_pkg::t_bin_addr          w_ram_waddr;
    tofh_pkg::t_count             w_ram_wdata;

    tofh_pkg::t_evt               w_evt;
    tofh_pkg::t_frame_sum         w_sum;

    logic                         n_result_valid;
    logic                         n_result_kind;
    logic [tofh_pkg::FRAME_W-1:0] n_frame_number;
    tofh_pkg::t_count             n_count;
    tofh_pkg::t_count             n_out_of_range_hits;
    logic                         r_result_valid;
    logic                         r_result_kind;
    logic [tofh_pkg::FRAME_W-1:0] r_frame_number;
    tofh_pkg::t_count             r_count;
    tofh_pkg::t_count             r_out_of_range_hits;

    // Handshakes.
    assign busy        = r_clr_active;
    assign w_accept    = start && !busy;
    assign o_cfg_ready = 1'b1;

    // Decode of the incoming transfer.
    assign w_time     = i_event_word[tofh_pkg::TIME_W-1:0];
    assign w_time_m1  = 32'(w_time) - 32'd1;
    assign w_bin_ext  = 32'(i_bin_address);
    assign w_is_start = (w_time == '0);
    assign w_in_range = (21'(w_time) <= 21'(tofh_pkg::HIST_BINS));
    assign w_addr_ok  = (w_bin_ext < 32'(tofh_pkg::HIST_BINS));
    assign w_ev_addr  = w_time_m1[tofh_pkg::BIN_AW-1:0];
    assign w_rd_addr  = w_bin_ext[tofh_pkg::BIN_AW-1:0];
    assign w_raddr    = (tofh_pkg::t_cmd'(i_command) == tofh_pkg::CMD_EVENT) ?
                        w_ev_addr : w_rd_addr;

    // Update stage registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_cmd      <= tofh_pkg::t_cmd'(i_command);
            r_s1_start    <= w_is_start;
            r_s1_in_range <= w_in_range;
            r_s1_addr_ok  <= w_addr_ok;
            r_s1_addr     <= w_raddr;
        end
    end

    // Frame size register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_size <= tofh_pkg::FRAME_W'(1);
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_frame_size <= i_cfg_data;
        end
    end

    // Clearing pass over the histogram after reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_active <= 1'b1;
            r_clr_addr   <= '0;
        end else if (r_clr_active) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == tofh_pkg::BIN_AW'(tofh_pkg::HIST_BINS - 1)) begin
                r_clr_active <= 1'b0;
            end
        end
    end

    // Bin value seen by the update stage, with forwarding of the last write.
    assign w_old = (r_fwd_valid && (r_fwd_addr == r_s1_addr)) ? r_fwd_data : w_ram_rdata;

    // Read-modify-write of the addressed bin.
    always_comb begin
        w_upd_we   = 1'b0;
        w_upd_data = '0;
        if (r_s1_valid) begin
            unique case (r_s1_cmd)
                tofh_pkg::CMD_EVENT: begin
                    w_upd_we   = !r_s1_start && r_s1_in_range;
                    w_upd_data = tofh_pkg::sat_inc(w_old);
                end
                tofh_pkg::CMD_READ_CLEAR: begin
                    w_upd_we   = r_s1_addr_ok;
                    w_upd_data = '0;
                end
                default: begin
                    w_upd_we   = 1'b0;
                    w_upd_data = '0;
                end
            endcase
        end
    end

    // Memory write port: clearing pass or bin update.
    assign w_ram_we    = r_clr_active || w_upd_we;
    assign w_ram_waddr = r_clr_active ? r_clr_addr : r_s1_addr;
    assign w_ram_wdata = r_clr_active ? '0 : w_upd_data;

    // Forwarding register for a read issued in the same cycle as a write.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_valid <= 1'b0;
        end else begin
            r_fwd_valid <= w_upd_we;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_upd_we) begin
            r_fwd_addr <= r_s1_addr;
            r_fwd_data <= w_upd_data;
        end
    end

    tofh_hist_ram u_hist_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_ram_rdata)
    );

    // Event handed to the framing logic.
    always_comb begin
        w_evt.valid    = r_s1_valid && (r_s1_cmd == tofh_pkg::CMD_EVENT);
        w_evt.is_start = r_s1_start;
        w_evt.in_range = r_s1_in_range;
    end

    tofh_frame_ctrl u_frame_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_evt        (w_evt),
        .i_frame_size (r_frame_size),
        .o_sum        (w_sum)
    );

    // Result selection.
    always_comb begin
        n_result_valid      = 1'b0;
        n_result_kind       = tofh_pkg::KIND_FRAME;
        n_frame_number      = '0;
        n_count             = '0;
        n_out_of_range_hits = '0;
        if (r_s1_valid) begin
            unique case (r_s1_cmd) inside
                tofh_pkg::CMD_READ, tofh_pkg::CMD_READ_CLEAR: begin
                    n_result_valid = 1'b1;
                    n_result_kind  = tofh_pkg::KIND_BIN;
                    n_count        = r_s1_addr_ok ? w_old : '0;
                end
                tofh_pkg::CMD_EVENT: begin
                    n_result_valid      = w_sum.close;
                    n_result_kind       = tofh_pkg::KIND_FRAME;
                    n_frame_number      = w_sum.number;
                    n_count             = w_sum.hits;
                    n_out_of_range_hits = w_sum.dropped;
                end
                default: begin
                    n_result_valid = 1'b0;
                end
            endcase
        end
    end

    // Output registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_result_valid <= 1'b0;
        end else begin
            r_result_valid <= n_result_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_result_kind       <= n_result_kind;
        r_frame_number      <= n_frame_number;
        r_count             <= n_count;
        r_out_of_range_hits <= n_out_of_range_hits;
    end

    assign o_result_valid      = r_result_valid;
    assign o_result_kind       = r_result_kind;
    assign o_frame_number      = r_frame_number;
    assign o_count             = r_count;
    assign o_out_of_range_hits = r_out_of_range_hits;

endmodule

`default_nettype wire

// ----- rtl/tofh_checker.sv -----
// ----------------------------------------------------------------------------
// tofh_checker
// Port-level checks of the histogrammer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module tofh_checker (
    input wire logic                              i_clk,
    input wire logic                              i_rst_n,
    input wire logic                              start,
    input wire logic                              busy,
    input wire logic [tofh_pkg::CMD_W-1:0]        i_command,
    input wire logic [tofh_pkg::ADDR_W-1:0]       i_bin_address,
    input wire logic                              o_result_valid,
    input wire logic                              o_result_kind,
    input wire logic [tofh_pkg::FRAME_W-1:0]      o_frame_number,
    input wire logic [tofh_pkg::CNT_W-1:0]        o_count,
    input wire logic [tofh_pkg::CNT_W-1:0]        o_out_of_range_hits
);

    // No result while the histogram is being cleared.
    a_no_result_when_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> !o_result_valid)
        else $error("result transfer during clearing pass");

    // Every result is registered from the update stage of an accepted transfer.
    a_result_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> $past(start && !busy, 2))
        else $error("result without a matching input transfer");

    // Bin reads carry no frame information.
    a_bin_read_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_result_kind == tofh_pkg::KIND_BIN) |->
        (o_frame_number == '0 && o_out_of_range_hits == '0))
        else $error("bin read result with frame fields set");

    // Out-of-range hits are part of the frame hit count.
    a_frame_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_result_kind == tofh_pkg::KIND_FRAME) |->
        (o_count >= o_out_of_range_hits))
        else $error("frame out-of-range total exceeds hit count");

    // A read right after a read-and-clear of the same bin sees zero.
    a_clear_forwarded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_command == tofh_pkg::CMD_READ_CLEAR) ##1
        (start && !busy && i_command == tofh_pkg::CMD_READ &&
         i_bin_address == $past(i_bin_address)) |->
        ##2 (o_result_valid && o_count == '0))
        else $error("cleared bin read back as nonzero");

endmodule

bind tof_histogram_frame_counter tofh_checker u_tofh_checker (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .start               (start),
    .busy                (busy),
    .i_command           (i_command),
    .i_bin_address       (i_bin_address),
    .o_result_valid      (o_result_valid),
    .o_result_kind       (o_result_kind),
    .o_frame_number      (o_frame_number),
    .o_count             (o_count),
    .o_out_of_range_hits (o_out_of_range_hits)
);

`default_nettype wire

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the time-of-flight histogrammer with frame counter.
// A driver feeds TDC event words and bin read commands from a queue, and a
// shadow copy of the histogram and framing state predicts every closed frame
// summary and bin readout. A monitor compares each result with the oldest
// prediction. Phases cover frame sizes zero, one, a few and the maximum.
// ----------------------------------------------------------------------------
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    // Command code that the block ignores.
    localparam logic [tofh_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

    // One input transfer.
    typedef struct {
        logic [tofh_pkg::CMD_W-1:0]  cmd;
        logic [tofh_pkg::WORD_W-1:0] word;
        logic [tofh_pkg::ADDR_W-1:0] addr;
    } t_tdc_item;

    // One result transfer.
    typedef struct {
        tofh_pkg::t_kind              kind;
        logic [tofh_pkg::FRAME_W-1:0] frame;
        tofh_pkg::t_count             count;
        tofh_pkg::t_count             dropped;
    } t_report;

    // Clock and reset.
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    // Command, configuration and result signals.
    logic                         start          = 1'b0;
    logic                         busy;
    logic [tofh_pkg::CMD_W-1:0]   i_command      = '0;
    logic [tofh_pkg::WORD_W-1:0]  i_event_word   = '0;
    logic [tofh_pkg::ADDR_W-1:0]  i_bin_address  = '0;
    logic                         i_cfg_valid    = 1'b0;
    logic                         o_cfg_ready;
    logic [tofh_pkg::FRAME_W-1:0] i_cfg_data     = '0;
    logic                         o_result_valid;
    logic                         o_result_kind;
    logic [tofh_pkg::FRAME_W-1:0] o_frame_number;
    logic [tofh_pkg::CNT_W-1:0]   o_count;
    logic [tofh_pkg::CNT_W-1:0]   o_out_of_range_hits;

    // Stimulus and expectation queues.
    t_tdc_item pending_items[$];
    t_report   expected_reports[$];
    int        sender_gap_pct = 0;

    // Shadow state of the histogrammer.
    tofh_pkg::t_count             hist_shadow [tofh_pkg::HIST_BINS];
    logic                         frame_open_shadow   = 1'b0;
    logic [tofh_pkg::FRAME_W-1:0] starts_shadow       = '0;
    tofh_pkg::t_count             hits_shadow         = '0;
    tofh_pkg::t_count             dropped_shadow      = '0;
    logic [tofh_pkg::FRAME_W-1:0] frame_index_shadow  = '0;
    logic [tofh_pkg::FRAME_W-1:0] frame_size_shadow   = 16'd1;

    // Run statistics.
    int items_accepted = 0;
    int frames_seen    = 0;
    int bins_seen      = 0;
    int cfg_writes     = 0;
    int mismatch_count = 0;

    tof_histogram_frame_counter u_dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .start               (start),
        .busy                (busy),
        .i_command           (i_command),
        .i_event_word        (i_event_word),
        .i_bin_address       (i_bin_address),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_data          (i_cfg_data),
        .o_result_valid      (o_result_valid),
        .o_result_kind       (o_result_kind),
        .o_frame_number      (o_frame_number),
        .o_count             (o_count),
        .o_out_of_range_hits (o_out_of_range_hits)
    );

    // Free-running clock.
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Hard limit on the run length.
    initial begin
        #2_000_000;
        $display("Timeout waiting for the block to finish its work.");
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Saturating increment of a 32-bit count.
    function automatic tofh_pkg::t_count bump(input tofh_pkg::t_count v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    // Bins a nonzero time or counts it as out of range.
    function automatic void bin_time(input logic [tofh_pkg::TIME_W-1:0] t);
        tofh_pkg::t_bin_addr idx;
        if (t == '0)
            return;
        idx = tofh_pkg::BIN_AW'(t - 1'b1);
        hits_shadow = bump(hits_shadow);
        if (int'(t) <= tofh_pkg::HIST_BINS)
            hist_shadow[idx] = bump(hist_shadow[idx]);
        else
            dropped_shadow = bump(dropped_shadow);
    endfunction

    // Advances the shadow state by one accepted item and queues its result.
    function automatic void apply_item(input t_tdc_item it);
        t_report                     r;
        logic [tofh_pkg::TIME_W-1:0] t;
        if (it.cmd == tofh_pkg::CMD_READ || it.cmd == tofh_pkg::CMD_READ_CLEAR) begin
            r.kind    = tofh_pkg::KIND_BIN;
            r.frame   = '0;
            r.count   = hist_shadow[it.addr];
            r.dropped = '0;
            if (it.cmd == tofh_pkg::CMD_READ_CLEAR)
                hist_shadow[it.addr] = '0;
            expected_reports.push_back(r);
            return;
        end
        if (it.cmd != tofh_pkg::CMD_EVENT)
            return;
        t = it.word[tofh_pkg::TIME_W-1:0];
        // The first event after reset opens frame zero, whatever its time.
        if (!frame_open_shadow) begin
            frame_open_shadow = 1'b1;
            starts_shadow     = 16'd1;
            hits_shadow       = '0;
            dropped_shadow    = '0;
            bin_time(t);
            return;
        end
        if (t != '0) begin
            bin_time(t);
            return;
        end
        // A start pulse either closes a full frame or joins the open one.
        if (starts_shadow >= frame_size_shadow) begin
            r.kind    = tofh_pkg::KIND_FRAME;
            r.frame   = frame_index_shadow;
            r.count   = hits_shadow;
            r.dropped = dropped_shadow;
            expected_reports.push_back(r);
            frame_index_shadow = frame_index_shadow + 1'b1;
            starts_shadow      = 16'd1;
            hits_shadow        = '0;
            dropped_shadow     = '0;
        end else if (starts_shadow != tofh_pkg::STARTS_MAX) begin
            starts_shadow = starts_shadow + 1'b1;
        end
    endfunction

    // Random item, weighted toward a few busy bins and frequent reads of them.
    function automatic t_tdc_item random_item();
        t_tdc_item                   it;
        int                          pick;
        logic [tofh_pkg::TIME_W-1:0] t;
        it.word = $urandom();
        it.addr = tofh_pkg::ADDR_W'($urandom());
        it.cmd  = tofh_pkg::CMD_EVENT;
        pick    = $urandom_range(99);
        if (pick < 70) begin
            pick = $urandom_range(99);
            if (pick < 25)
                t = '0;
            else if (pick < 65)
                t = tofh_pkg::TIME_W'($urandom_range(16, 1));
            else if (pick < 75)
                t = tofh_pkg::TIME_W'($urandom_range(tofh_pkg::HIST_BINS,
                                                     tofh_pkg::HIST_BINS - 15));
            else if (pick < 85)
                t = tofh_pkg::TIME_W'($urandom_range(tofh_pkg::HIST_BINS, 1));
            else
                t = tofh_pkg::TIME_W'($urandom_range(20'hFFFFF, tofh_pkg::HIST_BINS + 1));
            it.word[tofh_pkg::TIME_W-1:0] = t;
        end else if (pick < 97) begin
            it.cmd = (pick < 85) ? tofh_pkg::CMD_READ : tofh_pkg::CMD_READ_CLEAR;
            pick   = $urandom_range(99);
            if (pick < 60)
                it.addr = tofh_pkg::ADDR_W'($urandom_range(15, 0));
            else if (pick < 80)
                it.addr = tofh_pkg::ADDR_W'($urandom_range(tofh_pkg::HIST_BINS - 1,
                                                           tofh_pkg::HIST_BINS - 17));
        end else begin
            it.cmd = CMD_UNUSED;
        end
        return it;
    endfunction

    task automatic queue_item(input logic [tofh_pkg::CMD_W-1:0] cmd,
                              input logic [tofh_pkg::WORD_W-1:0] word,
                              input logic [tofh_pkg::ADDR_W-1:0] addr);
        t_tdc_item it;
        it.cmd  = cmd;
        it.word = word;
        it.addr = addr;
        pending_items.push_back(it);
    endtask

    task automatic queue_random(input int n);
        repeat (n) pending_items.push_back(random_item());
    endtask

    // Holds the test sequence back until every item is taken and every result is in.
    task automatic settle();
        do @(posedge i_clk); while (pending_items.size() != 0 || expected_reports.size() != 0);
        // Items without a result may still be in the pipeline.
        repeat (4) @(posedge i_clk);
    endtask

    // One transfer on the configuration channel.
    task automatic write_frame_size(input logic [tofh_pkg::FRAME_W-1:0] value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        frame_size_shadow = value;
        cfg_writes++;
        i_cfg_valid <= 1'b0;
    endtask

    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("Mismatch in %s at %0t ns: expected 0x%08h, got 0x%08h",
                         field, $time, want, got);
        end
    endtask

    // Driver: takes the next pending item at each accepted transfer.
    always @(posedge i_clk) begin : drive_items
        t_tdc_item taken;
        bit        send;
        if (i_rst_n && start && !busy) begin
            taken.cmd  = i_command;
            taken.word = i_event_word;
            taken.addr = i_bin_address;
            apply_item(taken);
            void'(pending_items.pop_front());
            items_accepted++;
        end
        send = i_rst_n && (pending_items.size() != 0)
               && ($urandom_range(99) >= sender_gap_pct);
        if (send) begin
            start         <= 1'b1;
            i_command     <= pending_items[0].cmd;
            i_event_word  <= pending_items[0].word;
            i_bin_address <= pending_items[0].addr;
        end else begin
            start <= 1'b0;
        end
    end

    // Monitor: every result strobe is matched against the oldest prediction.
    always @(posedge i_clk) begin : watch_results
        t_report want;
        if (i_rst_n && o_result_valid) begin
            if (o_result_kind == tofh_pkg::KIND_FRAME)
                frames_seen++;
            else
                bins_seen++;
            if (expected_reports.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("Unexpected result at %0t ns: kind %0d count 0x%08h",
                             $time, o_result_kind, o_count);
            end else begin
                want = expected_reports.pop_front();
                check_field("result_kind", 32'(want.kind), 32'(o_result_kind));
                check_field("frame_number", 32'(want.frame), 32'(o_frame_number));
                check_field("count", want.count, o_count);
                check_field("out_of_range_hits", want.dropped, o_out_of_range_hits);
            end
        end
    end

    // Reset, directed checks, then random phases at several frame sizes.
    initial begin
        foreach (hist_shadow[k])
            hist_shadow[k] = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Frame size zero behaves as one; hits at both ends of the histogram,
        // out-of-range times, reads, read and clear, and the ignored command.
        sender_gap_pct = 30;
        write_frame_size(16'd0);
        queue_item(tofh_pkg::CMD_EVENT, 32'hE000_0005, 12'd0);
        queue_item(tofh_pkg::CMD_EVENT, 32'h0000_0001, 12'd0);
        queue_item(tofh_pkg::CMD_EVENT, 32'h0000_1000, 12'd0);
        queue_item(tofh_pkg::CMD_EVENT, 32'h0000_1001, 12'd0);
        queue_item(tofh_pkg::CMD_EVENT, 32'hFFFF_FFFF, 12'hFFF);
        queue_item(tofh_pkg::CMD_EVENT, 32'h1FF0_0000, 12'd0);
        queue_item(tofh_pkg::CMD_READ, 32'h0, 12'd0);
        queue_item(tofh_pkg::CMD_READ, 32'hFFFF_FFFF, 12'hFFF);
        queue_item(tofh_pkg::CMD_READ_CLEAR, 32'h0, 12'd4);
        queue_item(tofh_pkg::CMD_READ, 32'h0, 12'd4);
        queue_item(CMD_UNUSED, 32'h0, 12'd4);
        queue_item(tofh_pkg::CMD_READ_CLEAR, 32'h0, 12'hFFF);
        queue_item(tofh_pkg::CMD_READ, 32'h0, 12'hFFF);
        queue_item(tofh_pkg::CMD_EVENT, 32'h0000_0000, 12'd0);
        queue_item(tofh_pkg::CMD_EVENT, 32'h0000_0003, 12'd0);
        queue_item(CMD_UNUSED, 32'h0000_0000, 12'd2);
        settle();

        // Frame size three: starts are absorbed until the frame is full.
        write_frame_size(16'd3);
        queue_item(tofh_pkg::CMD_EVENT, 32'h2000_0000, 12'd0);
        queue_item(tofh_pkg::CMD_EVENT, 32'h0000_0000, 12'd0);
        queue_item(tofh_pkg::CMD_EVENT, 32'h0000_0002, 12'd0);
        queue_item(tofh_pkg::CMD_EVENT, 32'h0000_0000, 12'd0);
        queue_item(tofh_pkg::CMD_EVENT, 32'h0000_0000, 12'd0);
        queue_item(tofh_pkg::CMD_READ, 32'h0, 12'd1);
        queue_item(tofh_pkg::CMD_EVENT, 32'h0000_0000, 12'd0);
        queue_item(tofh_pkg::CMD_EVENT, 32'h0000_0000, 12'd0);
        settle();

        // Largest frame size: the frame stays open and only reads report.
        write_frame_size(16'hFFFF);
        queue_random(60);
        settle();

        // Back to single-start frames; the long frame closes on its next start.
        write_frame_size(16'd1);
        queue_random(300);
        settle();

        sender_gap_pct = 55;
        write_frame_size(16'd2);
        queue_random(300);
        settle();

        sender_gap_pct = 0;
        write_frame_size(16'd7);
        queue_random(290);
        settle();

        $display("Covered %0d accepted items with %0d closed frames and %0d bin reads,",
                 items_accepted, frames_seen, bins_seen);
        $display("across %0d frame size writes (zero, one, two, three, seven, maximum).",
                 cfg_writes);
        if (mismatch_count == 0 && expected_reports.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("%0d mismatches, %0d results still outstanding.",
                     mismatch_count, expected_reports.size());
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ----- files.f -----
rtl/tofh_pkg.sv
rtl/tofh_hist_ram.sv
rtl/tofh_frame_ctrl.sv
rtl/tof_histogram_frame_counter.sv
rtl/tofh_checker.sv
tb/tb.sv
